// ===== design/pdhs_pkg.sv =====
// ----------------------------------------------------------------------------
// pdhs_pkg
// Shared widths, register indexes, codes and handshake structs of the pedal
// direction hysteresis scaler.
// ----------------------------------------------------------------------------
package pdhs_pkg;

	localparam int SAMPLE_W  = 10;
	localparam int TIME_W    = 32;
	localparam int PEDAL_W   = 2;
	localparam int LEVEL_W   = 7;
	localparam int SETTLE_W  = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int NUM_W     = SAMPLE_W + LEVEL_W;
	localparam int S_DATA_W  = 48;
	localparam int M_DATA_W  = 8;

	localparam logic [CFG_IDX_W-1:0] REG_CALIB_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CALIB_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BAND       = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE_MS  = 2'd3;

	localparam logic [SAMPLE_W-1:0] CALIB_LOW_RST  = 10'd9;
	localparam logic [SAMPLE_W-1:0] CALIB_HIGH_RST = 10'd1010;
	localparam logic [SAMPLE_W-1:0] BAND_RST       = 10'd30;
	localparam logic [SETTLE_W-1:0] SETTLE_MS_RST  = 16'd50;

	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd127;

	typedef enum logic [1:0] {
		DIR_IDLE = 2'd0,
		DIR_UP   = 2'd1,
		DIR_DOWN = 2'd2
	} dir_t;

	typedef enum logic [1:0] {
		LVL_ZERO = 2'd0,
		LVL_FULL = 2'd1,
		LVL_DIV  = 2'd2,
		LVL_SKIP = 2'd3
	} lvl_mode_t;

	typedef enum logic [2:0] {
		ST_IDLE      = 3'd0,
		ST_UPDATE    = 3'd1,
		ST_DIV_START = 3'd2,
		ST_DIV_WAIT  = 3'd3,
		ST_EMIT      = 3'd4
	} state_t;

	typedef struct packed {
		logic load;
		logic update;
		logic div_start;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} status_t;

endpackage

// ===== design/pdhs_div.sv =====
// ----------------------------------------------------------------------------
// pdhs_div
// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the quotient fits in LEVEL_W bits (upper dividend bits below the divisor).
// ----------------------------------------------------------------------------
module pdhs_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [pdhs_pkg::NUM_W-1:0]        num,
	input  logic [pdhs_pkg::SAMPLE_W-1:0]     den,
	output logic                              done,
	output logic [pdhs_pkg::LEVEL_W-1:0]      quo
);
	import pdhs_pkg::*;

	localparam int CNT_W = $clog2(LEVEL_W);

	logic [SAMPLE_W-1:0] rem_q;
	logic [LEVEL_W-1:0]  dvd_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [SAMPLE_W+1:0] trial;
	logic                ge;
	logic [SAMPLE_W-1:0] rem_next;

	always_comb begin
		trial    = {1'b0, rem_q, dvd_q[LEVEL_W-1]} - {2'b00, den};
		ge       = ~trial[SAMPLE_W+1];
		rem_next = ge ? trial[SAMPLE_W-1:0] : {rem_q[SAMPLE_W-2:0], dvd_q[LEVEL_W-1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(LEVEL_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend bits shift out the top while quotient bits shift in below
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[NUM_W-1:LEVEL_W];
			dvd_q <= num[LEVEL_W-1:0];
		end else if (busy_q) begin
			rem_q <= rem_next;
			dvd_q <= {dvd_q[LEVEL_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = dvd_q;

endmodule

// ===== design/pdhs_ctrl.sv =====
// ----------------------------------------------------------------------------
// pdhs_ctrl
// Sequencer: takes one item, steps the datapath through state update and
// division, and owns the output valid flag.
// ----------------------------------------------------------------------------
module pdhs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  pdhs_pkg::status_t status,
	output pdhs_pkg::cmd_t    cmd
);
	import pdhs_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = ~out_valid_q | m_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:      if (s_tvalid) state_d = ST_UPDATE;
			ST_UPDATE:    state_d = ST_DIV_START;
			ST_DIV_START: state_d = ST_DIV_WAIT;
			ST_DIV_WAIT:  if (status.div_done) state_d = ST_EMIT;
			ST_EMIT:      if (out_free) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_UPDATE:    cmd.update = 1'b1;
			ST_DIV_START: cmd.div_start = 1'b1;
			ST_DIV_WAIT:  cmd = '0;
			ST_EMIT:      cmd.emit = out_free;
			default:      cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

// ===== design/pdhs_dp.sv =====
// ----------------------------------------------------------------------------
// pdhs_dp
// Datapath: configuration registers, per-pedal hysteresis state, scaling
// through the serial divider, and the output payload register.
// ----------------------------------------------------------------------------
module pdhs_dp #(
	parameter int PEDAL_COUNT = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pdhs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pdhs_pkg::CFG_W-1:0]      cfg_data,
	input  logic [pdhs_pkg::PEDAL_W-1:0]    in_pedal,
	input  logic [pdhs_pkg::SAMPLE_W-1:0]   in_sample,
	input  logic [pdhs_pkg::TIME_W-1:0]     in_now,
	input  pdhs_pkg::cmd_t                  cmd,
	output pdhs_pkg::status_t               status,
	output logic [pdhs_pkg::PEDAL_W-1:0]    out_pedal,
	output logic [pdhs_pkg::LEVEL_W-1:0]    out_level,
	output logic                            out_changed
);
	import pdhs_pkg::*;

	localparam int IDX_W = (PEDAL_COUNT > 1) ? $clog2(PEDAL_COUNT) : 1;

	logic [SAMPLE_W-1:0] calib_low_q;
	logic [SAMPLE_W-1:0] calib_high_q;
	logic [SAMPLE_W-1:0] band_q;
	logic [SETTLE_W-1:0] settle_q;

	logic [PEDAL_W-1:0]  pedal_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic [TIME_W-1:0]   now_q;

	logic [SAMPLE_W-1:0] held_q [PEDAL_COUNT];
	dir_t                dir_q  [PEDAL_COUNT];
	logic [TIME_W-1:0]   adv_q  [PEDAL_COUNT];
	logic [LEVEL_W-1:0]  last_q [PEDAL_COUNT];

	lvl_mode_t           mode_q;
	logic [NUM_W-1:0]    num_q;
	logic [SAMPLE_W-1:0] span_q;

	logic [PEDAL_W-1:0]  pedal_out_q;
	logic [LEVEL_W-1:0]  level_out_q;
	logic                changed_out_q;

	logic [IDX_W-1:0]    idx;
	logic                in_range;
	logic [SAMPLE_W-1:0] held;
	dir_t                dir;
	logic [TIME_W-1:0]   adv;
	logic [TIME_W-1:0]   elapsed;
	logic                settled;
	logic [SAMPLE_W:0]   s_ext;
	logic [SAMPLE_W:0]   held_ext;
	logic [SAMPLE_W:0]   band_ext;
	logic [SAMPLE_W-1:0] held_new;
	dir_t                dir_new;
	logic [TIME_W-1:0]   adv_new;
	logic [SAMPLE_W-1:0] diff;
	logic [NUM_W-1:0]    num;
	lvl_mode_t           mode;
	logic                div_done;
	logic [LEVEL_W-1:0]  quo;
	logic [LEVEL_W-1:0]  level_val;
	logic                changed;

	assign idx      = IDX_W'(pedal_q);
	assign in_range = {{(32-PEDAL_W){1'b0}}, pedal_q} < 32'(PEDAL_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_low_q  <= CALIB_LOW_RST;
			calib_high_q <= CALIB_HIGH_RST;
			band_q       <= BAND_RST;
			settle_q     <= SETTLE_MS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CALIB_LOW:  calib_low_q  <= cfg_data[SAMPLE_W-1:0];
				REG_CALIB_HIGH: calib_high_q <= cfg_data[SAMPLE_W-1:0];
				REG_BAND:       band_q       <= cfg_data[SAMPLE_W-1:0];
				REG_SETTLE_MS:  settle_q     <= cfg_data[SETTLE_W-1:0];
				default:        settle_q     <= settle_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pedal_q  <= in_pedal;
			sample_q <= in_sample;
			now_q    <= in_now;
		end
	end

	// hysteresis step for the selected pedal
	always_comb begin
		held     = held_q[idx];
		dir      = dir_q[idx];
		adv      = adv_q[idx];
		elapsed  = now_q - adv;
		settled  = elapsed >= TIME_W'(settle_q);
		s_ext    = {1'b0, sample_q};
		held_ext = {1'b0, held};
		band_ext = {1'b0, band_q};
		held_new = held;
		dir_new  = dir;
		adv_new  = adv;
		case (dir)
			DIR_IDLE: begin
				if (s_ext > held_ext + band_ext) begin
					dir_new  = DIR_UP;
					held_new = sample_q;
					adv_new  = now_q;
				end else if (s_ext + band_ext < held_ext) begin
					dir_new  = DIR_DOWN;
					held_new = sample_q;
					adv_new  = now_q;
				end
			end
			default: begin
				if (settled) begin
					dir_new = DIR_IDLE;
					adv_new = '0;
				end else if (dir == DIR_UP) begin
					if (sample_q > held) begin
						held_new = sample_q;
						adv_new  = now_q;
					end
				end else if (sample_q < held) begin
					held_new = sample_q;
					adv_new  = now_q;
				end
			end
		endcase
	end

	// at or above calib_high the quotient is at least 127, so clamp directly
	always_comb begin
		diff = held_new - calib_low_q;
		num  = {diff, {LEVEL_W{1'b0}}} - NUM_W'(diff);
		if (!in_range) begin
			mode = LVL_SKIP;
		end else if (calib_high_q <= calib_low_q || held_new <= calib_low_q) begin
			mode = LVL_ZERO;
		end else if (held_new >= calib_high_q) begin
			mode = LVL_FULL;
		end else begin
			mode = LVL_DIV;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			mode_q <= mode;
			num_q  <= (mode == LVL_DIV) ? num : '0;
			span_q <= calib_high_q - calib_low_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PEDAL_COUNT; k++) begin
				held_q[k] <= '0;
				dir_q[k]  <= DIR_IDLE;
				adv_q[k]  <= '0;
				last_q[k] <= '0;
			end
		end else begin
			if (cmd.update && in_range) begin
				held_q[idx] <= held_new;
				dir_q[idx]  <= dir_new;
				adv_q[idx]  <= adv_new;
			end
			if (cmd.emit && changed) begin
				last_q[idx] <= level_val;
			end
		end
	end

	pdhs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (num_q),
		.den    (span_q),
		.done   (div_done),
		.quo    (quo)
	);

	assign status.div_done = div_done;

	always_comb begin
		case (mode_q)
			LVL_ZERO: level_val = '0;
			LVL_FULL: level_val = LEVEL_MAX;
			LVL_DIV:  level_val = quo;
			LVL_SKIP: level_val = '0;
			default:  level_val = '0;
		endcase
		changed = (mode_q != LVL_SKIP) && (level_val != last_q[idx]);
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			pedal_out_q   <= pedal_q;
			level_out_q   <= level_val;
			changed_out_q <= changed;
		end
	end

	assign out_pedal   = pedal_out_q;
	assign out_level   = level_out_q;
	assign out_changed = changed_out_q;

endmodule

// ===== design/pedal_direction_hysteresis_scaler.sv =====
// ----------------------------------------------------------------------------
// pedal_direction_hysteresis_scaler
// Per-pedal directional hysteresis with settle timeout and linear scaling
// of the held level onto 0..127.
//
//   Input items arrive on the s_ group: pedal index in s_tuser, sample and
//   millisecond time stamp in s_tdata. Every item yields exactly one result
//   on the m_ group: pedal index in m_tuser, level and changed flag in
//   m_tdata.
//   Configuration (calib_low, calib_high, band, settle_ms at indexes 0..3)
//   is written through cfg_we/cfg_index/cfg_data; write it only while the
//   block is idle, which the block itself does not enforce. After acceptance
//   an item passes the update state, the divider start, the 7-step serial
//   divider that does the scaling and the emit state; only then is the
//   next item accepted. Results sit in an output register; the next item
//   is accepted while a result still waits. If the receiver stalls, the
//   block finishes the following item and holds it until the output
//   register frees up. Reset restores the default calibration and clears
//   all pedal state; an item is accepted as soon as reset is released.
// ----------------------------------------------------------------------------
module pedal_direction_hysteresis_scaler #(
	parameter int PEDAL_COUNT = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pdhs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pdhs_pkg::CFG_W-1:0]      cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [pdhs_pkg::S_DATA_W-1:0]   s_tdata,   // sample[9:0], now_ms[41:10], zero
	input  logic [pdhs_pkg::PEDAL_W-1:0]    s_tuser,   // pedal[1:0]
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [pdhs_pkg::M_DATA_W-1:0]   m_tdata,   // level[6:0], changed[7]
	output logic [pdhs_pkg::PEDAL_W-1:0]    m_tuser    // pedal_out[1:0]
);
	import pdhs_pkg::*;

	cmd_t               cmd;
	status_t            status;
	logic [LEVEL_W-1:0] level;
	logic               changed;

	pdhs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	pdhs_dp #(
		.PEDAL_COUNT (PEDAL_COUNT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_pedal    (s_tuser),
		.in_sample   (s_tdata[SAMPLE_W-1:0]),
		.in_now      (s_tdata[SAMPLE_W+TIME_W-1:SAMPLE_W]),
		.cmd         (cmd),
		.status      (status),
		.out_pedal   (m_tuser),
		.out_level   (level),
		.out_changed (changed)
	);

	assign m_tdata = {changed, level};

endmodule

// ===== tb/pdhs_checker.sv =====
// ----------------------------------------------------------------------------
// pdhs_checker
// Watches the configuration port and both streams of the pedal scaler. It
// keeps its own copy of the per-pedal hysteresis state and the calibration,
// predicts the result of every accepted item, and compares each delivered
// result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module pdhs_checker #(
	parameter int PEDAL_COUNT = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pdhs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pdhs_pkg::CFG_W-1:0]      cfg_data,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [pdhs_pkg::S_DATA_W-1:0]   s_tdata,   // sample[9:0], now_ms[41:10], zero
	input  logic [pdhs_pkg::PEDAL_W-1:0]    s_tuser,   // pedal[1:0]
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [pdhs_pkg::M_DATA_W-1:0]   m_tdata,   // level[6:0], changed[7]
	input  logic [pdhs_pkg::PEDAL_W-1:0]    m_tuser,   // pedal_out[1:0]
	output int                              errors,
	output int                              pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import pdhs_pkg::*;

	typedef struct packed {
		logic [PEDAL_W-1:0] pedal;
		logic [LEVEL_W-1:0] level;
		logic               changed;
	} pedal_result_t;

	logic [SAMPLE_W-1:0] calib_lo;
	logic [SAMPLE_W-1:0] calib_hi;
	logic [SAMPLE_W-1:0] band_w;
	logic [SETTLE_W-1:0] settle_w;

	logic [SAMPLE_W-1:0] held [PEDAL_COUNT];
	dir_t                dir [PEDAL_COUNT];
	logic [TIME_W-1:0]   adv_ms [PEDAL_COUNT];
	logic [LEVEL_W-1:0]  stored_lvl [PEDAL_COUNT];

	pedal_result_t expected_q [$];
	int            err_cnt = 0;

	task automatic report_mismatch(input string what, input int got_v, input int want_v);
		err_cnt++;
		if (err_cnt <= 50) begin
			$display("[%0t] pedal result mismatch: %s got %0d expected %0d",
				$time, what, got_v, want_v);
		end
	endtask

	function automatic logic [LEVEL_W-1:0] scale_to_level(input logic [SAMPLE_W-1:0] raw);
		int q;
		if (calib_hi <= calib_lo || raw <= calib_lo) return '0;
		q = (int'(raw - calib_lo) * 127) / int'(calib_hi - calib_lo);
		return (q > 127) ? LEVEL_MAX : q[LEVEL_W-1:0];
	endfunction

	// Advance the hysteresis state of one pedal and return its result.
	function automatic pedal_result_t predict_item(input logic [PEDAL_W-1:0] pd,
			input logic [SAMPLE_W-1:0] smp, input logic [TIME_W-1:0] ts);
		pedal_result_t r;
		int s;
		int h;
		int b;
		logic [TIME_W-1:0] elapsed;
		logic [LEVEL_W-1:0] lvl;
		r.pedal = pd;
		r.level = '0;
		r.changed = 1'b0;
		if (int'(pd) >= PEDAL_COUNT) return r;
		s = int'(smp);
		h = int'(held[pd]);
		b = int'(band_w);
		// wraps modulo 2^32 like the time stamps themselves
		elapsed = ts - adv_ms[pd];
		if (dir[pd] == DIR_IDLE) begin
			if (s > h + b) begin
				dir[pd] = DIR_UP;
				held[pd] = smp;
				adv_ms[pd] = ts;
			end else if (s < h - b) begin
				dir[pd] = DIR_DOWN;
				held[pd] = smp;
				adv_ms[pd] = ts;
			end
		end else if (elapsed >= TIME_W'(settle_w)) begin
			// settle: drop to idle, this sample is not used
			dir[pd] = DIR_IDLE;
			adv_ms[pd] = '0;
		end else if (dir[pd] == DIR_UP) begin
			if (s > h) begin
				held[pd] = smp;
				adv_ms[pd] = ts;
			end
		end else if (s < h) begin
			held[pd] = smp;
			adv_ms[pd] = ts;
		end
		lvl = scale_to_level(held[pd]);
		r.changed = (lvl != stored_lvl[pd]);
		stored_lvl[pd] = lvl;
		r.level = lvl;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pedal_result_t want;
		pedal_result_t got;
		if (!arst_n) begin
			calib_lo = CALIB_LOW_RST;
			calib_hi = CALIB_HIGH_RST;
			band_w = BAND_RST;
			settle_w = SETTLE_MS_RST;
			for (int k = 0; k < PEDAL_COUNT; k++) begin
				held[k] = '0;
				dir[k] = DIR_IDLE;
				adv_ms[k] = '0;
				stored_lvl[k] = '0;
			end
			expected_q.delete();
			errors <= err_cnt;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_CALIB_LOW:  calib_lo = cfg_data[SAMPLE_W-1:0];
					REG_CALIB_HIGH: calib_hi = cfg_data[SAMPLE_W-1:0];
					REG_BAND:       band_w = cfg_data[SAMPLE_W-1:0];
					REG_SETTLE_MS:  settle_w = cfg_data[SETTLE_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				expected_q.push_back(predict_item(s_tuser, s_tdata[SAMPLE_W-1:0],
					s_tdata[SAMPLE_W +: TIME_W]));
			end
			if (m_tvalid && m_tready) begin
				got.pedal = m_tuser;
				got.level = m_tdata[LEVEL_W-1:0];
				got.changed = m_tdata[LEVEL_W];
				if (expected_q.size() == 0) begin
					report_mismatch("result with no item pending, pedal",
						int'(got.pedal), -1);
				end else begin
					want = expected_q.pop_front();
					if (got.pedal != want.pedal)
						report_mismatch("pedal_out", int'(got.pedal), int'(want.pedal));
					if (got.level != want.level)
						report_mismatch("level", int'(got.level), int'(want.level));
					if (got.changed != want.changed)
						report_mismatch("changed", int'(got.changed), int'(want.changed));
				end
			end
			errors <= err_cnt;
			pending <= expected_q.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives the pedal scaler with a short directed run of pedal gestures, then
// random gestures under several calibration, band and settle settings,
// with bursty input and a stalling receiver. The checker predicts and
// compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pdhs_pkg::*;

	localparam int PEDALS       = 4;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 16;

	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_BEAT
	} rx_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_DATA_W-1:0]  s_tdata = '0;   // sample[9:0], now_ms[41:10], zero
	logic [PEDAL_W-1:0]   s_tuser = '0;   // pedal[1:0]
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_DATA_W-1:0]  m_tdata;        // level[6:0], changed[7]
	logic [PEDAL_W-1:0]   m_tuser;        // pedal_out[1:0]

	int mismatches;
	int outstanding;

	int       burst_left = 0;
	int       gap_max = 0;
	int       cur_settle = int'(SETTLE_MS_RST);
	int       idle_cycles = 0;
	rx_mode_t rx_mode = RX_OPEN;
	int       rx_left = 0;

	logic [TIME_W-1:0] now_ms = '0;
	int walk_pos [PEDALS];
	int walk_dir [PEDALS];

	pedal_direction_hysteresis_scaler #(.PEDAL_COUNT(PEDALS)) dut (.*);

	pdhs_checker #(.PEDAL_COUNT(PEDALS)) u_checker (
		.*,
		.errors(mismatches),
		.pending(outstanding)
	);

	always #1 clk = ~clk;

	// receiver: switch between open, coin-flip, sparse and beat stall patterns
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_mode <= RX_OPEN;
			rx_left <= 0;
		end else begin
			if (rx_left == 0) begin
				rx_mode <= rx_mode_t'($urandom_range(0, 3));
				rx_left <= $urandom_range(8, 120);
			end else begin
				rx_left <= rx_left - 1;
			end
			case (rx_mode)
				RX_OPEN:   m_tready <= 1'b1;
				RX_COIN:   m_tready <= ($urandom_range(0, 1) != 0);
				RX_SPARSE: m_tready <= ($urandom_range(0, 7) == 0);
				default:   m_tready <= rx_left[2];
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("FAILURE");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic put_item(input logic [PEDAL_W-1:0] pd, input logic [SAMPLE_W-1:0] smp,
			input logic [TIME_W-1:0] ts);
		int gap;
		if (burst_left == 0) begin
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(S_DATA_W-TIME_W-SAMPLE_W){1'b0}}, ts, smp};
		s_tuser <= pd;
		do @(posedge clk); while (!s_tready);
		burst_left--;
	endtask

	// Hold input off until every pending result has come back.
	task automatic drain();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic wr_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_W-1:0];
		@(posedge clk);
	endtask

	task automatic random_items(input int n);
		logic [PEDAL_W-1:0] pd;
		logic [SAMPLE_W-1:0] smp;
		int roll;
		int stepv;
		int nxt;
		for (int i = 0; i < n; i++) begin
			pd = PEDAL_W'($urandom_range(0, PEDALS - 1));
			roll = $urandom_range(0, 99);
			if (roll < 8)
				now_ms += cur_settle + $urandom_range(0, 3);   // let movement settle
			else if (roll < 11)
				now_ms = $urandom;
			else if (roll < 14)
				now_ms += cur_settle - 1;
			else
				now_ms += $urandom_range(0, cur_settle / 4 + 2);
			if (roll >= 90) begin
				smp = (roll >= 96) ? {SAMPLE_W{roll[0]}} : SAMPLE_W'($urandom);
			end else begin
				// advance a per-pedal gesture, reverse now and then
				if ($urandom_range(0, 15) == 0) walk_dir[pd] = -walk_dir[pd];
				stepv = $urandom_range(0, 40);
				nxt = walk_pos[pd] + walk_dir[pd] * stepv;
				if (nxt > 1023) begin
					nxt = 1023;
					walk_dir[pd] = -1;
				end else if (nxt < 0) begin
					nxt = 0;
					walk_dir[pd] = 1;
				end
				walk_pos[pd] = nxt;
				smp = nxt[SAMPLE_W-1:0];
			end
			put_item(pd, smp, now_ms);
		end
	endtask

	task automatic run_phase(input int lo, input int hi, input int bd, input int st,
			input int gaps, input int n);
		drain();
		wr_reg(REG_CALIB_LOW, lo);
		wr_reg(REG_CALIB_HIGH, hi);
		wr_reg(REG_BAND, bd);
		wr_reg(REG_SETTLE_MS, st);
		cfg_we <= 1'b0;
		cur_settle = st;
		gap_max = gaps;
		random_items(n);
	endtask

	initial begin
		for (int k = 0; k < PEDALS; k++) begin
			walk_pos[k] = $urandom_range(0, 1023);
			walk_dir[k] = $urandom_range(0, 1) ? 1 : -1;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// band edge, rise to full scale, settle exactly at the timeout, then fall
		put_item(2'd0, 10'd0,    32'd0);
		put_item(2'd0, 10'd30,   32'd1);
		put_item(2'd0, 10'd31,   32'd2);
		put_item(2'd0, 10'd1023, 32'd3);
		put_item(2'd0, 10'd0,    32'd52);
		put_item(2'd0, 10'd0,    32'd53);
		put_item(2'd0, 10'd0,    32'd54);
		// calibration end points and a falling start just past the band edge
		put_item(2'd1, 10'd9,    32'd0);
		put_item(2'd1, 10'd1010, 32'd5);
		put_item(2'd1, 10'd600,  32'd40);
		put_item(2'd1, 10'd600,  32'd55);
		put_item(2'd1, 10'd980,  32'd60);
		put_item(2'd1, 10'd979,  32'd61);
		// movement across a wrap of the millisecond clock
		put_item(2'd2, 10'd512,  32'hFFFF_FFE0);
		put_item(2'd2, 10'd700,  32'h0000_0010);
		put_item(2'd2, 10'd800,  32'h0000_0041);
		put_item(2'd2, 10'd800,  32'h0000_0073);
		put_item(2'd3, 10'd1023, 32'hFFFF_FFFF);
		put_item(2'd3, 10'd1,    32'h8000_0000);
		put_item(2'd3, 10'd0,    32'h8000_0001);
		put_item(2'd2, 10'h155,  32'h5555_5555);
		put_item(2'd1, 10'h2AA,  32'hAAAA_AAAA);
		now_ms = 32'hAAAA_AB00;

		random_items(110);
		run_phase(0,    1023, 0,    0,     6,  110);
		run_phase(1022, 1023, 1023, 65535, 3,  110);
		run_phase(9,    1010, 30,   50,    20, 110);
		run_phase(500,  500,  10,   20,    2,  110);
		run_phase(800,  100,  5,    10,    0,  110);
		run_phase(0,    1,    1023, 1,     4,  60);
		repeat (3) begin
			run_phase($urandom_range(0, 1022), $urandom_range(1, 1023),
				$urandom_range(0, 120), $urandom_range(0, 400),
				$urandom_range(0, 10), 100);
		end
		run_phase(100,  900,  20,   50,    8,  80);

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
